[hw/rtl/bdq_pkg.sv]
// types, codes and defaults shared by the bounded deque cell row and its control
package bdq_pkg;

    localparam int MAX_SLOTS = 8;
    localparam int WORD_BITS = 32;

    localparam logic [3:0] LIMIT_RESET = 4'd3;

    typedef enum logic [2:0] {
        CMD_PUSH_HEAD    = 3'd0,
        CMD_PUSH_TAIL    = 3'd1,
        CMD_INSERT_AFTER = 3'd2,
        CMD_POP_HEAD     = 3'd3,
        CMD_POP_TAIL     = 3'd4,
        CMD_REMOVE_AFTER = 3'd5
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_FULL   = 3'd1,
        ST_EMPTY  = 3'd2,
        ST_NOKEY  = 3'd3,
        ST_NOSUCC = 3'd4
    } t_status;

    // where the gap opens or closes in the row
    typedef enum logic [1:0] {
        POS_ZERO  = 2'd0,
        POS_COUNT = 2'd1,
        POS_LAST  = 2'd2,
        POS_AFTER = 2'd3
    } t_pos_sel;

    typedef struct packed {
        logic [2:0]  command;
        logic [31:0] match_key;
        logic [31:0] new_word;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] removed_word;
        logic [3:0]  entry_count;
        logic [3:0]  space_left;
    } t_out_item;

    // action applied to the whole row this cycle
    typedef struct packed {
        logic ins;
        logic rem;
    } t_act;

    // flags handed from a cell to its right neighbor
    typedef struct packed {
        logic seen;  // key matched at or left of this cell
        logic ge;    // this cell is at or right of the gap position
        logic succ;  // a held cell follows the first match
    } t_link;

endpackage

[hw/rtl/bdq_cell.sv]
// one slot of the deque: holds a word, compares it and shifts with its neighbors
module bdq_cell #(
    parameter int WORD_BITS = bdq_pkg::WORD_BITS,
    parameter int CW        = 4,
    parameter int IDX       = 0
) (
    input  logic                 i_clk,
    input  bdq_pkg::t_pos_sel    i_pos,
    input  bdq_pkg::t_act        i_act,
    input  logic [CW-1:0]        i_count,
    input  logic [WORD_BITS-1:0] i_key,
    input  logic [WORD_BITS-1:0] i_new_word,
    input  logic [WORD_BITS-1:0] i_left_word,
    input  logic [WORD_BITS-1:0] i_right_word,
    input  bdq_pkg::t_link       i_link,
    input  logic [WORD_BITS-1:0] i_rem_word,
    output bdq_pkg::t_link       o_link,
    output logic [WORD_BITS-1:0] o_rem_word,
    output logic [WORD_BITS-1:0] o_word
);

    logic [WORD_BITS-1:0] r_word;
    logic [WORD_BITS-1:0] n_word;
    logic                 w_valid;
    logic                 w_eq;
    logic                 w_ge;
    logic                 w_is_pos;

    assign w_valid = CW'(IDX) < i_count;
    assign w_eq    = w_valid && (r_word == i_key);

    always_comb begin
        case (i_pos)
            bdq_pkg::POS_ZERO:  w_ge = 1'b1;
            bdq_pkg::POS_COUNT: w_ge = CW'(IDX) >= i_count;
            bdq_pkg::POS_LAST:  w_ge = CW'(IDX + 1) >= i_count;
            bdq_pkg::POS_AFTER: w_ge = i_link.seen;
            default:            w_ge = 1'b0;
        endcase
    end

    assign w_is_pos = w_ge && !i_link.ge;

    assign o_link.seen = i_link.seen | w_eq;
    assign o_link.ge   = w_ge;
    assign o_link.succ = i_link.succ | (i_link.seen & w_valid);
    assign o_rem_word  = i_rem_word | (w_is_pos ? r_word : '0);
    assign o_word      = r_word;

    always_comb begin
        n_word = r_word;
        if (i_act.ins && w_ge) begin
            n_word = w_is_pos ? i_new_word : i_left_word;
        end else if (i_act.rem && w_ge) begin
            n_word = i_right_word;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

endmodule

[hw/rtl/bounded_deque_with_key_insert_remove.sv]
// bounded deque with key search, insert after match and remove after match
//
//  channel   ports                     direction  handshake
//  command   start, busy, i_cmd        in         taken when start & !busy
//  result    o_done, o_result          out        one-cycle strobe, no stall
//  config    i_cfg_we, i_cfg_wdata     in         capacity limit written on we
//
// the accept edge latches a command, and the edge that ends the execute state runs one
// compare-and-shift pass along the row of slot cells and registers the result
// the result strobe sits in the cycle after that, when busy is already low, so
// a new command can be taken at the same edge that takes the result
// synchronous active-low reset clears the count, the limit (to 3) and control;
// slot words are not reset and only held slots are ever read
// the receiver cannot stall, so nothing holds the result back
module bounded_deque_with_key_insert_remove #(
    parameter int MAX_SLOTS = bdq_pkg::MAX_SLOTS,
    parameter int WORD_BITS = bdq_pkg::WORD_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  bdq_pkg::t_in_item  i_cmd,
    output logic               o_done,
    output bdq_pkg::t_out_item o_result,
    input  logic               i_cfg_we,
    input  logic [3:0]         i_cfg_wdata
);

    // count width holds 0..MAX_SLOTS; compare width also covers the 4-bit limit
    localparam int CW = $clog2(MAX_SLOTS + 1);
    localparam int EW = (CW > 4) ? CW : 4;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state              r_state, n_state;
    bdq_pkg::t_in_item   r_cmd;
    logic [CW-1:0]       r_count, n_count;
    logic [3:0]          r_limit;
    bdq_pkg::t_out_item  r_out, n_out;
    logic                r_done;

    logic                w_accept;
    logic                w_exec;
    logic [WORD_BITS-1:0] w_key, w_new_word;
    logic [EW-1:0]       w_lim, w_cnt_next_e;
    logic                w_full, w_empty;
    bdq_pkg::t_pos_sel   w_pos;
    bdq_pkg::t_act       w_act;
    bdq_pkg::t_status    w_status;

    bdq_pkg::t_link       w_link [MAX_SLOTS+1];
    logic [WORD_BITS-1:0] w_rem  [MAX_SLOTS+1];
    logic [WORD_BITS-1:0] w_word [MAX_SLOTS];

    assign w_accept = start && !busy;
    assign w_exec   = (r_state == S_EXEC);
    assign busy     = w_exec;

    // input words are cut or zero-extended to the slot width
    assign w_key      = WORD_BITS'(r_cmd.match_key);
    assign w_new_word = WORD_BITS'(r_cmd.new_word);

    // effective limit is the smaller of the register and the row length
    assign w_lim   = (EW'(r_limit) < EW'(MAX_SLOTS)) ? EW'(r_limit) : EW'(MAX_SLOTS);
    assign w_full  = EW'(r_count) >= w_lim;
    assign w_empty = (r_count == '0);

    // gap position for each command
    always_comb begin
        case (bdq_pkg::t_cmd'(r_cmd.command))
            bdq_pkg::CMD_PUSH_HEAD:    w_pos = bdq_pkg::POS_ZERO;
            bdq_pkg::CMD_PUSH_TAIL:    w_pos = bdq_pkg::POS_COUNT;
            bdq_pkg::CMD_INSERT_AFTER: w_pos = bdq_pkg::POS_AFTER;
            bdq_pkg::CMD_POP_HEAD:     w_pos = bdq_pkg::POS_ZERO;
            bdq_pkg::CMD_POP_TAIL:     w_pos = bdq_pkg::POS_LAST;
            bdq_pkg::CMD_REMOVE_AFTER: w_pos = bdq_pkg::POS_AFTER;
            default:                   w_pos = bdq_pkg::POS_ZERO;
        endcase
    end

    // row of slot cells, flags and the removed word ripple head to tail
    assign w_link[0] = '0;
    assign w_rem[0]  = '0;

    for (genvar g = 0; g < MAX_SLOTS; g++) begin : g_cell
        logic [WORD_BITS-1:0] w_left, w_right;
        if (g == 0) begin : g_head
            assign w_left = w_new_word;
        end else begin : g_mid
            assign w_left = w_word[g-1];
        end
        if (g == MAX_SLOTS - 1) begin : g_tail
            assign w_right = w_word[g];
        end else begin : g_body
            assign w_right = w_word[g+1];
        end

        bdq_cell #(
            .WORD_BITS (WORD_BITS),
            .CW        (CW),
            .IDX       (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_pos        (w_pos),
            .i_act        (w_act),
            .i_count      (r_count),
            .i_key        (w_key),
            .i_new_word   (w_new_word),
            .i_left_word  (w_left),
            .i_right_word (w_right),
            .i_link       (w_link[g]),
            .i_rem_word   (w_rem[g]),
            .o_link       (w_link[g+1]),
            .o_rem_word   (w_rem[g+1]),
            .o_word       (w_word[g])
        );
    end

    // status and row action from the count and the ripple results
    always_comb begin
        w_status = bdq_pkg::ST_OK;
        w_act    = '0;
        case (bdq_pkg::t_cmd'(r_cmd.command))
            bdq_pkg::CMD_PUSH_HEAD, bdq_pkg::CMD_PUSH_TAIL: begin
                if (w_full) w_status = bdq_pkg::ST_FULL;
                else        w_act.ins = 1'b1;
            end
            bdq_pkg::CMD_INSERT_AFTER: begin
                if (w_full)                       w_status = bdq_pkg::ST_FULL;
                else if (w_empty)                 w_status = bdq_pkg::ST_EMPTY;
                else if (!w_link[MAX_SLOTS].seen) w_status = bdq_pkg::ST_NOKEY;
                else                              w_act.ins = 1'b1;
            end
            bdq_pkg::CMD_POP_HEAD, bdq_pkg::CMD_POP_TAIL: begin
                if (w_empty) w_status = bdq_pkg::ST_EMPTY;
                else         w_act.rem = 1'b1;
            end
            bdq_pkg::CMD_REMOVE_AFTER: begin
                if (w_empty)                      w_status = bdq_pkg::ST_EMPTY;
                else if (!w_link[MAX_SLOTS].seen) w_status = bdq_pkg::ST_NOKEY;
                else if (!w_link[MAX_SLOTS].succ) w_status = bdq_pkg::ST_NOSUCC;
                else                              w_act.rem = 1'b1;
            end
            default: begin
                w_status = bdq_pkg::ST_OK;
            end
        endcase
        // the row only moves in the execute cycle
        if (!w_exec) w_act = '0;
    end

    always_comb begin
        n_count = r_count;
        if (w_act.ins)      n_count = r_count + CW'(1);
        else if (w_act.rem) n_count = r_count - CW'(1);
    end

    assign w_cnt_next_e = EW'(n_count);

    always_comb begin
        n_out.status       = w_status;
        n_out.removed_word = w_act.rem ? 32'(w_rem[MAX_SLOTS]) : 32'd0;
        n_out.entry_count  = 4'(n_count);
        n_out.space_left   = (w_cnt_next_e < w_lim) ? 4'(w_lim - w_cnt_next_e) : 4'd0;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_accept) n_state = S_EXEC;
            S_EXEC:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_limit <= bdq_pkg::LIMIT_RESET;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= w_exec;
            if (i_cfg_we) r_limit <= i_cfg_wdata;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (w_accept) r_cmd <= i_cmd;
        if (w_exec)   r_out <= n_out;
    end

    assign o_done   = r_done;
    assign o_result = r_out;

    // an accepted command is in execute on the next cycle
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> w_exec)
        else $error("accepted command did not enter execute");

    // every execute cycle yields exactly one result strobe
    a_exec_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_exec |=> o_done)
        else $error("execute cycle without result strobe");

    // the result strobe only follows an execute cycle
    a_done_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(w_exec))
        else $error("result strobe without execute");

    // the count never goes beyond the row
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_SLOTS))
        else $error("entry count beyond slot row");

    // the row never inserts and removes together
    a_act_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_act.ins && w_act.rem))
        else $error("insert and remove in the same pass");

endmodule

[tb/sv/bounded_deque_with_key_insert_remove_test.sv]
// testbench for the bounded deque: directed command table, then random phases checked by a predictor
`timescale 1ns / 1ps

module bounded_deque_with_key_insert_remove_test;

    import bdq_pkg::*;

    // command codes the block treats as no operation
    localparam logic [2:0] CMD_UNUSED_6 = 3'd6;
    localparam logic [2:0] CMD_UNUSED_7 = 3'd7;

    localparam int POOL_SIZE = 6;
    localparam int PHASE_ITEMS = 78;
    localparam int PHASES = 8;

    // one row of the directed table, with the result typed in where it is obvious
    typedef struct {
        t_in_item  item;
        logic      has_exp;
        t_out_item result;
    } t_dir_row;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start = 1'b0;
    logic      busy;
    t_in_item  i_cmd = '0;
    logic      o_done;
    t_out_item o_result;
    logic      i_cfg_we = 1'b0;
    logic [3:0] i_cfg_wdata = 4'd0;

    // typed expectation travels with the item so the monitor picks it up at accept
    logic      typed_valid = 1'b0;
    t_out_item typed_result = '0;

    // predictor copy of the store, the count and the capacity register
    logic [31:0] deque_words [MAX_SLOTS];
    int          deque_count;
    logic [3:0]  deque_limit;

    t_out_item pending_results [$];
    int        fail_count = 0;
    logic [31:0] word_pool [POOL_SIZE];

    bounded_deque_with_key_insert_remove DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_cmd      (i_cmd),
        .o_done     (o_done),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // open a gap at pos and store the word there
    function automatic void insert_word(input int pos, input logic [31:0] w);
        for (int i = deque_count; i > pos; i--) deque_words[i] = deque_words[i - 1];
        deque_words[pos] = w;
        deque_count++;
    endfunction

    // close the gap at pos and hand back the word that was there
    function automatic logic [31:0] take_word(input int pos);
        logic [31:0] w;
        w = deque_words[pos];
        for (int i = pos; i + 1 < deque_count; i++) deque_words[i] = deque_words[i + 1];
        deque_count--;
        return w;
    endfunction

    // apply one command to the predictor and return the result it should give
    function automatic t_out_item deque_apply(input t_in_item c);
        t_out_item r;
        int        lim;
        int        hit;
        logic      full;
        r = '0;
        // a limit beyond the row is clipped to the row size
        lim = (deque_limit < MAX_SLOTS) ? int'(deque_limit) : MAX_SLOTS;
        full = (deque_count >= lim);
        // first match searched from the head, count when absent
        hit = deque_count;
        for (int i = deque_count - 1; i >= 0; i--)
            if (deque_words[i] == c.match_key) hit = i;
        case (c.command)
            CMD_PUSH_HEAD: begin
                if (full) r.status = ST_FULL;
                else insert_word(0, c.new_word);
            end
            CMD_PUSH_TAIL: begin
                if (full) r.status = ST_FULL;
                else insert_word(deque_count, c.new_word);
            end
            CMD_INSERT_AFTER: begin
                // full wins over empty
                if (full) r.status = ST_FULL;
                else if (deque_count == 0) r.status = ST_EMPTY;
                else if (hit >= deque_count) r.status = ST_NOKEY;
                else insert_word(hit + 1, c.new_word);
            end
            CMD_POP_HEAD: begin
                if (deque_count == 0) r.status = ST_EMPTY;
                else r.removed_word = take_word(0);
            end
            CMD_POP_TAIL: begin
                if (deque_count == 0) r.status = ST_EMPTY;
                else r.removed_word = take_word(deque_count - 1);
            end
            CMD_REMOVE_AFTER: begin
                if (deque_count == 0) r.status = ST_EMPTY;
                else if (hit >= deque_count) r.status = ST_NOKEY;
                else if (hit + 1 >= deque_count) r.status = ST_NOSUCC;
                else r.removed_word = take_word(hit + 1);
            end
            default: begin
            end
        endcase
        r.entry_count = deque_count[3:0];
        r.space_left = (deque_count < lim) ? 4'(lim - deque_count) : 4'd0;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %h actual %h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    // monitor: samples pre-edge values, so ordering against the driver does not matter
    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item pred;
        if (!i_rst_n) begin
            deque_count = 0;
            deque_limit = LIMIT_RESET;
        end else begin
            // a result is compared with the oldest item still owed
            if (o_done === 1'b1) begin
                if (pending_results.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none actual %h",
                             $time, o_result);
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("status", 32'(want.status), 32'(o_result.status));
                    check_field("removed_word", want.removed_word, o_result.removed_word);
                    check_field("entry_count", 32'(want.entry_count),
                                32'(o_result.entry_count));
                    check_field("space_left", 32'(want.space_left),
                                32'(o_result.space_left));
                end
            end
            if (i_cfg_we) deque_limit = i_cfg_wdata;
            // an item is taken when start is high and busy is low
            if (start && !busy) begin
                pred = deque_apply(i_cmd);
                pending_results.push_back(typed_valid ? typed_result : pred);
            end
        end
    end

    // words mostly come from a small pool so that keys hit held entries
    function automatic logic [31:0] pick_word();
        int roll;
        roll = $urandom_range(99);
        if (roll < 70) return word_pool[$urandom_range(POOL_SIZE - 1)];
        if (roll < 75) return 32'h0000_0000;
        if (roll < 80) return 32'hffff_ffff;
        return $urandom;
    endfunction

    // grow_pct sets how often the command adds a word rather than removes one
    function automatic t_in_item random_command(input int grow_pct);
        t_in_item c;
        int       roll;
        roll = $urandom_range(99);
        c.match_key = pick_word();
        c.new_word = pick_word();
        if (roll < 4) begin
            c.command = $urandom_range(1) ? CMD_UNUSED_6 : CMD_UNUSED_7;
        end else if (roll < 4 + grow_pct) begin
            case ($urandom_range(2))
                0: c.command = CMD_PUSH_HEAD;
                1: c.command = CMD_PUSH_TAIL;
                default: c.command = CMD_INSERT_AFTER;
            endcase
        end else begin
            case ($urandom_range(2))
                0: c.command = CMD_POP_HEAD;
                1: c.command = CMD_POP_TAIL;
                default: c.command = CMD_REMOVE_AFTER;
            endcase
        end
        return c;
    endfunction

    // called at a rising edge, returns at the edge where the item was taken
    task automatic send_command(input t_in_item c, input logic has_exp, input t_out_item exp);
        start <= 1'b1;
        i_cmd <= c;
        typed_valid <= has_exp;
        typed_result <= exp;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic idle_cycles(input int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // hold off until every owed result has come back, checked away from the sampling edge
    task automatic wait_drained();
        start <= 1'b0;
        @(negedge i_clk);
        while (pending_results.size() != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [3:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // directed table, run at the reset limit of 3 from an empty store
    t_dir_row dir_rows [24] = '{
        // empty store after reset
        '{'{CMD_POP_HEAD, 32'h0, 32'h0}, 1'b1, '{ST_EMPTY, 32'h0, 4'd0, 4'd3}},
        '{'{CMD_POP_TAIL, 32'h0, 32'h0}, 1'b1, '{ST_EMPTY, 32'h0, 4'd0, 4'd3}},
        '{'{CMD_REMOVE_AFTER, 32'h0, 32'h0}, 1'b1, '{ST_EMPTY, 32'h0, 4'd0, 4'd3}},
        // insert into an empty store reports empty
        '{'{CMD_INSERT_AFTER, 32'h0, 32'h1}, 1'b1, '{ST_EMPTY, 32'h0, 4'd0, 4'd3}},
        '{'{CMD_UNUSED_6, 32'hffff_ffff, 32'hffff_ffff}, 1'b1, '{ST_OK, 32'h0, 4'd0, 4'd3}},
        // fill to the limit with extreme words
        '{'{CMD_PUSH_TAIL, 32'h0, 32'h0}, 1'b1, '{ST_OK, 32'h0, 4'd1, 4'd2}},
        '{'{CMD_PUSH_HEAD, 32'h0, 32'hffff_ffff}, 1'b1, '{ST_OK, 32'h0, 4'd2, 4'd1}},
        '{'{CMD_INSERT_AFTER, 32'hffff_ffff, 32'h1234_5678}, 1'b1,
          '{ST_OK, 32'h0, 4'd3, 4'd0}},
        // full store: every add reports full, even with a matching key
        '{'{CMD_PUSH_TAIL, 32'h0, 32'h5}, 1'b1, '{ST_FULL, 32'h0, 4'd3, 4'd0}},
        '{'{CMD_PUSH_HEAD, 32'h0, 32'h5}, 1'b1, '{ST_FULL, 32'h0, 4'd3, 4'd0}},
        '{'{CMD_INSERT_AFTER, 32'h0, 32'h7}, 1'b1, '{ST_FULL, 32'h0, 4'd3, 4'd0}},
        '{'{CMD_REMOVE_AFTER, 32'hdead_beef, 32'h0}, 1'b1, '{ST_NOKEY, 32'h0, 4'd3, 4'd0}},
        // match on the tail has nothing after it
        '{'{CMD_REMOVE_AFTER, 32'h0, 32'h0}, 1'b1, '{ST_NOSUCC, 32'h0, 4'd3, 4'd0}},
        '{'{CMD_REMOVE_AFTER, 32'hffff_ffff, 32'h0}, 1'b0, '0},
        // successor is the tail, so the match becomes the tail
        '{'{CMD_REMOVE_AFTER, 32'hffff_ffff, 32'h0}, 1'b0, '0},
        '{'{CMD_INSERT_AFTER, 32'h55, 32'h9}, 1'b1, '{ST_NOKEY, 32'h0, 4'd1, 4'd2}},
        '{'{CMD_UNUSED_7, 32'h0, 32'h0}, 1'b1, '{ST_OK, 32'h0, 4'd1, 4'd2}},
        '{'{CMD_POP_TAIL, 32'h0, 32'h0}, 1'b1, '{ST_OK, 32'hffff_ffff, 4'd0, 4'd3}},
        // duplicates: insert and remove act on the first match only
        '{'{CMD_PUSH_HEAD, 32'h0, 32'ha5a5_a5a5}, 1'b0, '0},
        '{'{CMD_PUSH_HEAD, 32'h0, 32'ha5a5_a5a5}, 1'b0, '0},
        '{'{CMD_INSERT_AFTER, 32'ha5a5_a5a5, 32'h5a5a_5a5a}, 1'b0, '0},
        '{'{CMD_REMOVE_AFTER, 32'h5a5a_5a5a, 32'h0}, 1'b0, '0},
        '{'{CMD_POP_HEAD, 32'h0, 32'h0}, 1'b0, '0},
        '{'{CMD_POP_HEAD, 32'h0, 32'h0}, 1'b0, '0}
    };

    // limits per random phase: full row, shrink below count, past the row, zero, and back
    logic [3:0] phase_limits [PHASES] = '{4'd8, 4'd1, 4'd15, 4'd0, 4'd5, 4'd2, 4'd7, 4'd3};

    initial begin
        int  grow_pct;
        bit  last_phase;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_command(dir_rows[i].item, dir_rows[i].has_exp, dir_rows[i].result);

        for (int p = 0; p < PHASES; p++) begin
            // limit changes only while nothing is in flight
            wait_drained();
            write_limit(phase_limits[p]);
            foreach (word_pool[k]) word_pool[k] = $urandom;
            // alternate between filling up and draining down
            grow_pct = (p % 2 == 0) ? 62 : 36;
            last_phase = (p == PHASES - 1);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // idle bursts in part of each phase, none in the closing phase
                if (!last_phase && (n % 40) < 25 && $urandom_range(4) == 0)
                    idle_cycles($urandom_range(16, 1));
                send_command(random_command(grow_pct), 1'b0, '0);
            end
        end

        wait_drained();
        // keep clocking a while longer to catch any stray result
        repeat (8) @(posedge i_clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // watchdog well past the slowest legal run
    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
